@@ hw/rtl/soc_pkg.sv @@
// ----------------------------------------------------------------------------
// soc_pkg
// Shared types and codes for the subsequence occurrence counter.
// ----------------------------------------------------------------------------
package soc_pkg;

    // s_tuser codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;   // write one pattern entry
        logic step;   // advance the prefix counters, capture a result
        logic clear;  // zero the counters after this step
    } soc_cmd_t;

endpackage

@@ hw/rtl/subsequence_occurrence_counter.sv @@
// ----------------------------------------------------------------------------
// subsequence_occurrence_counter
// Counts the ways a loaded pattern occurs as an ordered subsequence of a
// streamed text, with saturating per-prefix counters.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser       tlast
// s_*      in   [3:0] position, [35:4] value, pad 0    func        last
// m_*      out  [31:0] count                           saturated   final_res
// cfg_*    in   wr_data[4:0] pattern_length, taken whenever cfg_wr_en is high
//
// One item per cycle while s_tready is high; all prefix counters update together.
// A text item's result is registered and appears the cycle after accept.
// s_tready stays high while the result register is empty or being drained.
// Loads produce no result. Reset clears counters and length; the pattern
// store is not reset.
// ----------------------------------------------------------------------------
module subsequence_occurrence_counter #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] position, [35:4] value, [39:36] zero
    input  logic        s_tuser,   // [0] func
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] count
    output logic        m_tuser,   // [0] saturated
    output logic        m_tlast,   // final_res
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);
    import soc_pkg::*;

    soc_cmd_t cmd;

    soc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    soc_datapath #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .position    (s_tdata[3:0]),
        .value       (s_tdata[35:4]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .count       (m_tdata),
        .saturated   (m_tuser),
        .final_res   (m_tlast)
    );

    // a text item always leaves a result behind, tagged with its last flag
    a_text_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_TEXT)
        |=> m_tvalid && (m_tlast == $past(s_tlast)))
        else $error("text item left no matching result");

    // a load accepted while no result is held or the held one drains leaves the output empty
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_LOAD) && (!m_tvalid || m_tready)
        |=> !m_tvalid)
        else $error("load item produced a result");

    // input stalls only behind a held, untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

endmodule

@@ hw/rtl/soc_ctrl.sv @@
// ----------------------------------------------------------------------------
// soc_ctrl
// Handshake controller: tracks the output register and issues datapath
// commands for each accepted item.
// ----------------------------------------------------------------------------
module soc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output soc_pkg::soc_cmd_t cmd
);
    import soc_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_text;

    // a held result drains in the same cycle a new one is captured
    assign s_tready = (state_reg == ST_EMPTY) || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_text  = (s_tuser == FUNC_TEXT);
    assign m_tvalid = (state_reg == ST_FULL);

    assign cmd.load  = accept && !is_text;
    assign cmd.step  = accept && is_text;
    assign cmd.clear = accept && is_text && s_tlast;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (accept && is_text)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (accept && is_text)
                    state_next = ST_FULL;
                else if (m_tready)
                    state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

@@ hw/rtl/soc_datapath.sv @@
// ----------------------------------------------------------------------------
// soc_datapath
// Pattern store, one saturating prefix counter per pattern entry, and the
// result register.
// ----------------------------------------------------------------------------
module soc_datapath #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  soc_pkg::soc_cmd_t  cmd,
    input  logic [3:0]         position,
    input  logic signed [31:0] value,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    output logic [31:0]        count,
    output logic               saturated,
    output logic               final_res
);
    import soc_pkg::*;

    logic signed [31:0]      pat_reg [PATTERN_MAX];
    logic [COUNT_BITS-1:0]   cnt_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]  sat_reg;
    logic [COUNT_BITS-1:0]   cnt_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]  sat_next;
    logic [4:0]              len_reg;

    logic [COUNT_BITS-1:0]   sel_cnt;
    logic                    sel_sat;
    logic [COUNT_BITS+31:0]  sel_ext;
    logic [31:0]             count_reg;
    logic [31:0]             count_next;
    logic                    sat_out_reg;
    logic                    sat_out_next;
    logic                    final_reg;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_lane
        logic [COUNT_BITS-1:0] add_val;
        logic                  add_sat;
        logic [COUNT_BITS:0]   sum;
        logic                  hit;

        if (j == 0)
        begin : g_first
            assign add_val = COUNT_BITS'(1);
            assign add_sat = 1'b0;
        end
        else
        begin : g_rest
            assign add_val = cnt_reg[j-1];
            assign add_sat = sat_reg[j-1];
        end

        assign sum = {1'b0, cnt_reg[j]} + {1'b0, add_val};
        assign hit = (pat_reg[j] == value);

        always_comb
        begin
            cnt_next[j] = cnt_reg[j];
            sat_next[j] = sat_reg[j];
            if (hit)
            begin
                if (sum[COUNT_BITS])
                begin
                    cnt_next[j] = '1;
                    sat_next[j] = 1'b1;
                end
                else
                begin
                    cnt_next[j] = sum[COUNT_BITS-1:0];
                end
                if (add_sat)
                    sat_next[j] = 1'b1;
            end
        end

        // out-of-range positions match no lane and are dropped
        always_ff @(posedge clk)
        begin
            if (cmd.load && (32'(position) == j))
                pat_reg[j] <= value;
        end
    end

    // pick the counter of the full pattern; lengths above the store use the top entry
    always_comb
    begin
        sel_cnt = '0;
        sel_sat = 1'b0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((32'(len_reg) == j + 1) ||
                ((j == PATTERN_MAX - 1) && (32'(len_reg) > PATTERN_MAX)))
            begin
                sel_cnt = cnt_next[j];
                sel_sat = sat_next[j];
            end
        end
    end

    assign sel_ext = {32'b0, sel_cnt};

    always_comb
    begin
        if (len_reg == 5'd0)
        begin
            count_next   = 32'd1;
            sat_out_next = 1'b0;
        end
        else
        begin
            count_next   = sel_ext[31:0];
            sat_out_next = sel_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
                cnt_reg[j] <= '0;
            sat_reg <= '0;
            len_reg <= 5'd0;
        end
        else
        begin
            if (cfg_wr_en)
                len_reg <= cfg_wr_data;
            if (cmd.step)
            begin
                for (int j = 0; j < PATTERN_MAX; j++)
                    cnt_reg[j] <= cmd.clear ? '0 : cnt_next[j];
                sat_reg <= cmd.clear ? '0 : sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            count_reg   <= count_next;
            sat_out_reg <= sat_out_next;
            final_reg   <= cmd.clear;
        end
    end

    assign count     = count_reg;
    assign saturated = sat_out_reg;
    assign final_res = final_reg;

endmodule

@@ test/subsequence_occurrence_counter_test.sv @@
// ----------------------------------------------------------------------------
// subsequence_occurrence_counter_test
// Self-checking bench for the subsequence occurrence counter. A queue of
// pattern loads, text items, length writes and flow-control markers feeds a
// clocked driver. The driver predicts the count for every accepted text item.
// A clocked monitor checks each result against the oldest prediction. Both
// sides idle at random, and long receiver stalls back the block up.
// ----------------------------------------------------------------------------
module subsequence_occurrence_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import soc_pkg::*;

    localparam int  SLOTS      = 16;
    localparam int  TAIL_ITEMS = 150;    // no idling once this few remain
    localparam int  HOLD_LEN   = 60;
    localparam int  RAND_ITEMS = 1200;
    localparam longint LIMIT   = 300000;

    typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN, ENT_HOLD} entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic        func;
        logic [3:0]  position;
        logic [31:0] value;
        logic        last;
        logic [4:0]  len;
    } entry_t;

    typedef struct {
        logic [31:0] count;
        logic        saturated;
        logic        final_res;
    } tally_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;
    logic        s_tuser     = FUNC_LOAD;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [4:0]  cfg_wr_data = '0;

    entry_t stim_q[$];
    tally_t tally_q[$];

    // predictor state
    logic [31:0] pat_store[SLOTS];
    logic [31:0] prefix_cnt[SLOTS];
    logic        prefix_sat[SLOTS];
    logic [4:0]  pat_len;

    int     fails     = 0;
    int     n_text    = 0;
    int     n_load    = 0;
    int     n_cfg     = 0;
    int     n_sat     = 0;
    int     n_final   = 0;
    longint cycles    = 0;
    logic   hold_req  = 1'b0;
    logic   sink_held = 1'b0;

    subsequence_occurrence_counter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     tally_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // advance every prefix counter from the old values, highest first
    function automatic tally_t count_text(logic [31:0] v, logic fin);
        tally_t      r;
        logic [32:0] sum;
        logic [31:0] add;
        logic        add_sat;
        int          j;
        int          eff;
        for (j = SLOTS - 1; j >= 0; j--)
        begin
            if (pat_store[j] == v)
            begin
                if (j == 0)
                begin
                    add     = 32'd1;
                    add_sat = 1'b0;
                end
                else
                begin
                    add     = prefix_cnt[j - 1];
                    add_sat = prefix_sat[j - 1];
                end
                sum = {1'b0, prefix_cnt[j]} + {1'b0, add};
                if (sum[32])
                begin
                    prefix_cnt[j] = '1;
                    prefix_sat[j] = 1'b1;
                end
                else
                    prefix_cnt[j] = sum[31:0];
                if (add_sat)
                    prefix_sat[j] = 1'b1;
            end
        end
        eff = (pat_len > SLOTS) ? SLOTS : int'(pat_len);
        if (eff == 0)
        begin
            r.count     = 32'd1;
            r.saturated = 1'b0;
        end
        else
        begin
            r.count     = prefix_cnt[eff - 1];
            r.saturated = prefix_sat[eff - 1];
        end
        r.final_res = fin;
        if (fin)
        begin
            for (j = 0; j < SLOTS; j++)
            begin
                prefix_cnt[j] = '0;
                prefix_sat[j] = 1'b0;
            end
        end
        return r;
    endfunction

    // ---------------- stimulus ----------------
    task automatic push_load(logic [3:0] pos, logic [31:0] v, logic lst);
        entry_t e;
        e = '{kind: ENT_ITEM, func: FUNC_LOAD, position: pos, value: v, last: lst, len: '0};
        stim_q.push_back(e);
        n_load++;
    endtask

    task automatic push_text(logic [31:0] v, logic lst);
        entry_t e;
        e = '{kind: ENT_ITEM, func: FUNC_TEXT, position: 4'($urandom), value: v, last: lst,
              len: '0};
        stim_q.push_back(e);
        n_text++;
    endtask

    task automatic push_mark(entry_kind_t k, logic [4:0] l);
        entry_t e;
        e = '{kind: k, func: FUNC_LOAD, position: '0, value: '0, last: 1'b0, len: l};
        stim_q.push_back(e);
        if (k == ENT_CFG)
            n_cfg++;
    endtask

    function automatic logic [4:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd2;
            3: return 5'd3;
            4: return 5'd16;
            5: return 5'd17;
            6: return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [31:0] pick_symbol();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [31:0] alpha[4];
        logic [31:0] v;
        int          phase;
        int          n;
        int          k;
        int          i;
        int          base;

        // every pattern slot is written before any text is streamed
        push_load(4'd0, 32'h8000_0000, 1'b0);
        push_load(4'd1, 32'h7fff_ffff, 1'b1);   // last is ignored on loads
        push_load(4'd2, 32'h0000_0000, 1'b0);
        push_load(4'd3, 32'hffff_ffff, 1'b0);
        for (i = 4; i < SLOTS; i++)
            push_load(4'(i), 32'd5, 1'b0);
        // empty pattern counts one
        push_text(32'hffff_ffff, 1'b0);
        push_text(32'h0000_0000, 1'b1);
        push_mark(ENT_CFG, 5'd4);
        push_text(32'h8000_0000, 1'b0);
        push_text(32'h7fff_ffff, 1'b0);
        push_text(32'h8000_0000, 1'b0);
        push_text(32'h0000_0000, 1'b0);
        push_text(32'hffff_ffff, 1'b1);
        // length above the slot count acts as full length
        push_mark(ENT_CFG, 5'd31);
        push_text(32'd5, 1'b0);
        push_mark(ENT_CFG, 5'd17);
        push_text(32'd5, 1'b1);
        push_mark(ENT_CFG, 5'd0);

        base  = n_text + n_load;
        phase = 0;
        while (n_text + n_load - base < RAND_ITEMS)
        begin
            phase++;
            for (i = 0; i < 4; i++)
                alpha[i] = pick_symbol();
            if (phase == 1 || $urandom_range(0, 2) == 0)
                push_mark(ENT_CFG, pick_len());
            if (phase == 2 || $urandom_range(0, 29) == 0)
            begin
                // long receiver stall while items keep coming
                push_mark(ENT_HOLD, '0);
                for (i = 0; i < 20; i++)
                    push_text(alpha[$urandom_range(0, 3)], 1'b0);
            end
            if (phase == 4 || $urandom_range(0, 9) == 0)
                push_mark(ENT_DRAIN, '0);

            if (phase == 3 || $urandom_range(0, 9) == 0)
            begin
                // all slots equal and a long matching run: drives saturation
                v = pick_symbol();
                push_mark(ENT_CFG, ($urandom_range(0, 1) != 0) ? 5'd16 : 5'd31);
                for (i = 0; i < SLOTS; i++)
                    push_load(4'(i), v, 1'($urandom));
                n = $urandom_range(38, 44);
                for (i = 0; i < n; i++)
                    push_text(v, i == n - 1);
            end
            else
            begin
                k = $urandom_range(0, 5);
                for (i = 0; i < k; i++)
                    push_load(($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                                          : 4'($urandom),
                              alpha[$urandom_range(0, 3)], 1'($urandom));
                n = $urandom_range(1, 30);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        push_load(4'($urandom_range(0, 3)), alpha[$urandom_range(0, 3)],
                                  1'($urandom));
                    if ($urandom_range(0, 9) == 0)
                        v = $urandom();
                    else
                        v = alpha[$urandom_range(0, 3)];
                    push_text(v, (i == n - 1) && ($urandom_range(0, 3) != 0));
                end
            end
        end

        @(posedge rst_n);
        while (stim_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (tally_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d text items and %0d loads over %0d length writes", n_text, n_load,
                 n_cfg);
        $display("%0d count runs ended, %0d results flagged saturated", n_final, n_sat);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ---------------- driver ----------------
    int gap_left     = 0;
    int gap_pct      = 0;
    int since_accept = 0;
    int drv_cycle    = 0;

    always @(posedge clk)
    begin
        entry_t      e;
        logic        nv;
        logic [39:0] nd;
        logic        nu;
        logic        nl;
        logic        ncfg;
        logic [4:0]  ncd;
        logic        nhold;
        int          j;
        if (!rst_n)
        begin
            for (j = 0; j < SLOTS; j++)
            begin
                prefix_cnt[j] = '0;
                prefix_sat[j] = 1'b0;
            end
            pat_len = '0;
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            nv    = s_tvalid;
            nd    = s_tdata;
            nu    = s_tuser;
            nl    = s_tlast;
            ncfg  = 1'b0;
            ncd   = cfg_wr_data;
            nhold = hold_req;

            drv_cycle++;
            if (drv_cycle % 128 == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            if (since_accept < 1000)
                since_accept++;

            if (s_tvalid && s_tready)
            begin
                since_accept = 0;
                if (s_tuser == FUNC_TEXT)
                    tally_q.push_back(count_text(s_tdata[35:4], s_tlast));
                else
                    pat_store[s_tdata[3:0]] = s_tdata[35:4];
                nv = 1'b0;
            end

            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stim_q.size() != 0)
                begin
                    e = stim_q[0];
                    case (e.kind)
                        ENT_ITEM:
                        begin
                            void'(stim_q.pop_front());
                            nv = 1'b1;
                            nd = {4'b0000, e.value, e.position};
                            nu = e.func;
                            nl = e.last;
                            if (stim_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < gap_pct)
                                gap_left = $urandom_range(1, 4);
                        end
                        ENT_CFG:
                        begin
                            // only once the block is idle; a load leaves no result
                            if (tally_q.size() == 0 && since_accept >= 3)
                            begin
                                void'(stim_q.pop_front());
                                ncfg    = 1'b1;
                                ncd     = e.len;
                                pat_len = e.len;
                            end
                        end
                        ENT_DRAIN:
                        begin
                            if (tally_q.size() == 0)
                                void'(stim_q.pop_front());
                        end
                        default:
                        begin
                            void'(stim_q.pop_front());
                            nhold = ~hold_req;
                        end
                    endcase
                end
            end

            s_tvalid    <= nv;
            s_tdata     <= nd;
            s_tuser     <= nu;
            s_tlast     <= nl;
            cfg_wr_en   <= ncfg;
            cfg_wr_data <= ncd;
            hold_req    <= nhold;
        end
    end

    // ---------------- long receiver stall ----------------
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left = HOLD_LEN;
        end
        else if (hold_left > 0)
            hold_left--;
        sink_held <= (hold_left > 0);
    end

    // ---------------- monitor ----------------
    int stall_left = 0;
    int stall_pct  = 0;
    int mon_cycle  = 0;

    always @(posedge clk)
    begin
        tally_t want;
        logic   nr;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (tally_q.size() == 0)
                begin
                    $error("result with nothing expected: count %0d", m_tdata);
                    fails++;
                end
                else
                begin
                    want = tally_q.pop_front();
                    if (m_tdata !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, m_tdata);
                        fails++;
                    end
                    if (m_tuser !== want.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b", want.saturated, m_tuser);
                        fails++;
                    end
                    if (m_tlast !== want.final_res)
                    begin
                        $error("final_res: expected %0b, actual %0b", want.final_res, m_tlast);
                        fails++;
                    end
                    if (want.saturated)
                        n_sat++;
                    if (want.final_res)
                        n_final++;
                end
            end

            mon_cycle++;
            if (mon_cycle % 96 == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            if (stall_left > 0)
                stall_left--;
            else if (stim_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 4);
            nr = !sink_held && (stall_left == 0);
            m_tready <= nr;
        end
    end

endmodule

@@ files.f @@
hw/rtl/soc_pkg.sv
hw/rtl/soc_ctrl.sv
hw/rtl/soc_datapath.sv
hw/rtl/subsequence_occurrence_counter.sv
test/subsequence_occurrence_counter_test.sv
